@@ rtl/rv32is_pkg.sv @@
package rv32is_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_WORD_BITS = MEM_ADDR_BITS - 2;
	localparam int MEM_WORDS     = 1 << MEM_WORD_BITS;
	localparam logic [31:0] MEM_BYTES   = 32'((64'd1 << MEM_ADDR_BITS));
	localparam logic [31:0] FETCH_LIMIT = 32'((64'd1 << MEM_ADDR_BITS) - 64'd4);
	localparam int RF_DEPTH = 32;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ILLEGAL  = 3'd1,
		ST_FAULT    = 3'd2,
		ST_MISALIGN = 3'd3,
		ST_HALTED   = 3'd4,
		ST_IMAGE    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_FETCH0,
		SQ_FETCH1,
		SQ_EXEC,
		SQ_MEM,
		SQ_FIN
	} seq_state_t;

	localparam logic [4:0] OP_LOAD     = 5'h00;
	localparam logic [4:0] OP_IMM      = 5'h04;
	localparam logic [4:0] OP_UPPER_PC = 5'h05;
	localparam logic [4:0] OP_MEM_WR   = 5'h08;
	localparam logic [4:0] OP_REG      = 5'h0C;
	localparam logic [4:0] OP_LUI      = 5'h0D;
	localparam logic [4:0] OP_CBR      = 5'h18;
	localparam logic [4:0] OP_JALR     = 5'h19;
	localparam logic [4:0] OP_JAL      = 5'h1B;
	localparam logic [4:0] OP_ENV      = 5'h1C;

	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

	typedef struct packed {
		status_t     status;
		logic        halt;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] wval;
		logic [31:0] npc;
		logic        ld;
		logic        st;
		logic [2:0]  f3;
		logic [31:0] eff;
		logic [31:0] sdata;
	} exec_res_t;

endpackage

@@ rtl/rv32is_ram.sv @@
module rv32is_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/rv32is_exec.sv @@
module rv32is_exec import rv32is_pkg::*; (
	input  logic [31:0] pc,
	input  logic [31:0] ins,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output exec_res_t   res
);

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] x,
			input logic [31:0] y, input logic alt);
		logic [31:0] r;
		case (f3)
			3'd0: r = alt ? x - y : x + y;
			3'd1: r = x << y[4:0];
			3'd2: r = {31'b0, $signed(x) < $signed(y)};
			3'd3: r = {31'b0, x < y};
			3'd4: r = x ^ y;
			3'd5: r = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
			3'd6: r = x | y;
			default: r = x & y;
		endcase
		return r;
	endfunction

	function automatic logic misal(input logic [1:0] sz, input logic [1:0] lo);
		return (sz == 2'd1 && lo[0]) || (sz == 2'd2 && lo != 2'd0);
	endfunction

	logic [4:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	logic [31:0] eff_l, eff_s;
	logic        taken;

	assign op    = ins[6:2];
	assign f3    = ins[14:12];
	assign f7    = ins[31:25];
	assign imm_i = {{20{ins[31]}}, ins[31:20]};
	assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
	assign eff_l = a + imm_i;
	assign eff_s = a + imm_s;

	always_comb begin
		case (f3)
			3'd0: taken = a == b;
			3'd1: taken = a != b;
			3'd4: taken = $signed(a) < $signed(b);
			3'd5: taken = $signed(a) >= $signed(b);
			3'd6: taken = a < b;
			3'd7: taken = a >= b;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		res.npc    = pc + 32'd4;
		res.rd     = ins[11:7];
		res.f3     = f3;
		res.sdata  = b;
		if (ins[1:0] != 2'b11 || ins[4:2] == 3'b111) begin
			res.status = ST_HALTED;
			res.halt   = 1'b1;
			res.npc    = pc;
		end else begin
			unique case (op)
				OP_LOAD: begin
					res.eff = eff_l;
					if (f3 == 3'd3 || f3 > 3'd5) res.status = ST_ILLEGAL;
					else if (misal(f3[1:0], eff_l[1:0])) res.status = ST_MISALIGN;
					else if (eff_l >= MEM_BYTES) res.status = ST_FAULT;
					else begin
						res.ld = 1'b1;
						res.wr = 1'b1;
					end
				end
				OP_MEM_WR: begin
					res.eff = eff_s;
					if (f3 > 3'd2) res.status = ST_ILLEGAL;
					else if (misal(f3[1:0], eff_s[1:0])) res.status = ST_MISALIGN;
					else if (eff_s >= MEM_BYTES) res.status = ST_FAULT;
					else res.st = 1'b1;
				end
				OP_IMM: begin
					if ((f3 == 3'd1 && f7 != F7_ZERO) ||
							(f3 == 3'd5 && f7 != F7_ZERO && f7 != F7_ALT)) begin
						res.status = ST_ILLEGAL;
					end else begin
						res.wr = 1'b1;
						if (f3 == 3'd1 || f3 == 3'd5)
							res.wval = alu(f3, a, {27'b0, ins[24:20]}, f7 == F7_ALT);
						else
							res.wval = alu(f3, a, imm_i, 1'b0);
					end
				end
				OP_REG: begin
					if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
						res.status = ST_ILLEGAL;
					end else begin
						res.wr   = 1'b1;
						res.wval = alu(f3, a, b, f7 == F7_ALT);
					end
				end
				OP_UPPER_PC: begin
					res.wr   = 1'b1;
					res.wval = pc + (ins & UPPER_MASK);
				end
				OP_LUI: begin
					res.wr   = 1'b1;
					res.wval = ins & UPPER_MASK;
				end
				OP_CBR: begin
					if (f3 == 3'd2 || f3 == 3'd3) res.status = ST_ILLEGAL;
					else if (taken) res.npc = pc + imm_b;
				end
				OP_JALR: begin
					if (f3 != 3'd0) begin
						res.status = ST_ILLEGAL;
					end else begin
						res.npc  = eff_l & ~32'd1;
						res.wr   = 1'b1;
						res.wval = pc + 32'd4;
					end
				end
				OP_JAL: begin
					res.npc  = pc + imm_j;
					res.wr   = 1'b1;
					res.wval = pc + 32'd4;
				end
				OP_ENV: begin
				end
				default: res.status = ST_ILLEGAL;
			endcase
		end
	end

endmodule

@@ rtl/rv32i_instruction_step.sv @@
// One-instruction-at-a-time RV32I machine.
// Input channel (in_valid/in_ready): req_type 0 writes image_data into the
// memory word image_addr; req_type 1 fetches at the PC and executes one
// instruction. Each transfer yields exactly one result on the output channel
// (out_valid/out_ready), carrying status, exec_pc, instr_word, the register
// write (dest_written, dest_reg, dest_value) and next_pc.
// An image write, a halted step or a fetch fault goes straight to the final
// stage; an instruction passes through fetch and execute, a load or store
// adds a memory step, and a PC that is not word aligned adds a second fetch.
// The order is set by the single read port of the data memory: fetch
// word(s), register read, then a data read for loads and a read-modify-write
// for stores, in turn. in_ready is low from the transfer until the result
// has been posted to the output register.
// A new item is taken once the previous one has been posted to the output
// register, so the next fetch overlaps a result still waiting downstream.
// When the receiver stalls, the result holds in the output register; a
// further finished item waits in the final stage until the slot frees.
// Reset clears the PC, the halt flag and the register-file valid bits (all
// registers read zero); main memory is not cleared and must be loaded first.
module rv32i_instruction_step import rv32is_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [13:0] image_addr,
	input  logic [31:0] image_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] exec_pc,
	output logic [31:0] instr_word,
	output logic        dest_written,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic [31:0] next_pc
);

	seq_state_t state_q, state_d;

	logic [31:0] pc_q;
	logic        halt_q;
	logic [RF_DEPTH-1:0] rf_vld_q;

	logic        img_q;
	logic [13:0] img_addr_q;
	logic [31:0] img_data_q;
	logic [31:0] w0_q;
	logic [31:0] ins_q;
	logic [31:0] memw_q;
	exec_res_t   res_q;
	exec_res_t   ex_res;
	exec_res_t   acc_res;

	logic        accept;
	logic        slot_free;
	logic        advance;
	logic        unaligned;
	logic        fetch_fault;

	// memory ports
	logic                     mem_we;
	logic [MEM_WORD_BITS-1:0] mem_waddr, mem_raddr;
	logic [31:0]              mem_wdata, mem_rdata;
	logic                     rf_we;
	logic [4:0]               rf_ra, rf_rb;
	logic [31:0]              rf_a_rdata, rf_b_rdata;
	logic [31:0]              ins_asm;
	logic [63:0]              pair;
	logic [31:0]              img_addr_ext;
	logic [31:0]              a_val, b_val;

	// load extraction and store merge
	logic [31:0] ld_sh, ld_val;
	logic [3:0]  st_bmask;
	logic [31:0] st_mask, st_rep, st_merged;

	assign accept      = in_valid && in_ready;
	assign slot_free   = !out_valid || out_ready;
	assign advance     = (state_q == SQ_FIN) && slot_free;
	assign unaligned   = pc_q[1:0] != 2'b00;
	assign fetch_fault = pc_q > FETCH_LIMIT;
	assign img_addr_ext = {18'b0, img_addr_q};

	// Assemble the instruction from one or two fetched words, little-endian.
	assign pair    = {mem_rdata, w0_q} >> {pc_q[1:0], 3'b000};
	assign ins_asm = (state_q == SQ_FETCH1) ? pair[31:0] : mem_rdata;

	assign a_val = rf_vld_q[ins_q[19:15]] ? rf_a_rdata : 32'd0;
	assign b_val = rf_vld_q[ins_q[24:20]] ? rf_b_rdata : 32'd0;

	rv32is_exec u_exec (
		.pc  (pc_q),
		.ins (ins_q),
		.a   (a_val),
		.b   (b_val),
		.res (ex_res)
	);

	// Result of an item that needs no fetch, or the seed of one that does.
	always_comb begin
		acc_res     = '0;
		acc_res.npc = pc_q;
		if (!req_type) acc_res.status = ST_IMAGE;
		else if (halt_q) acc_res.status = ST_HALTED;
		else if (fetch_fault) acc_res.status = ST_FAULT;
		else acc_res.status = ST_OK;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					if (!req_type || halt_q || fetch_fault) state_d = SQ_FIN;
					else state_d = SQ_FETCH0;
				end
			end
			SQ_FETCH0: state_d = unaligned ? SQ_FETCH1 : SQ_EXEC;
			SQ_FETCH1: state_d = SQ_EXEC;
			SQ_EXEC:   state_d = (ex_res.ld || ex_res.st) ? SQ_MEM : SQ_FIN;
			SQ_MEM:    state_d = SQ_FIN;
			SQ_FIN:    if (slot_free) state_d = SQ_IDLE;
			default:   state_d = SQ_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and memory port control.
	always_comb begin
		in_ready  = 1'b0;
		mem_raddr = pc_q[MEM_ADDR_BITS-1:2];
		mem_we    = 1'b0;
		mem_waddr = res_q.eff[MEM_ADDR_BITS-1:2];
		mem_wdata = memw_q;
		rf_we     = 1'b0;
		rf_ra     = ins_asm[19:15];
		rf_rb     = ins_asm[24:20];
		unique case (state_q)
			SQ_IDLE:   in_ready = 1'b1;
			SQ_FETCH0: mem_raddr = pc_q[MEM_ADDR_BITS-1:2] + 1'b1;
			SQ_FETCH1: ;
			SQ_EXEC:   mem_raddr = ex_res.eff[MEM_ADDR_BITS-1:2];
			SQ_MEM:    ;
			SQ_FIN: begin
				if (advance) begin
					// commit the image word or the store, and the register write
					if (img_q) begin
						mem_we    = 1'b1;
						mem_waddr = img_addr_ext[MEM_WORD_BITS-1:0];
						mem_wdata = img_data_q;
					end else if (res_q.st) begin
						mem_we = 1'b1;
					end
					rf_we = res_q.wr && res_q.rd != 5'd0;
				end
			end
			default: ;
		endcase
	end

	rv32is_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Two copies of the register file give two reads a cycle.
	rv32is_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_q.rd),
		.wdata (res_q.wval),
		.raddr (rf_ra),
		.rdata (rf_a_rdata)
	);

	rv32is_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_q.rd),
		.wdata (res_q.wval),
		.raddr (rf_rb),
		.rdata (rf_b_rdata)
	);

	// Load lane select and extension.
	assign ld_sh = mem_rdata >> {res_q.eff[1:0], 3'b000};
	always_comb begin
		case (res_q.f3)
			3'd0:    ld_val = {{24{ld_sh[7]}}, ld_sh[7:0]};
			3'd1:    ld_val = {{16{ld_sh[15]}}, ld_sh[15:0]};
			3'd4:    ld_val = {24'b0, ld_sh[7:0]};
			3'd5:    ld_val = {16'b0, ld_sh[15:0]};
			default: ld_val = ld_sh;
		endcase
	end

	// Store lane merge into the word just read.
	always_comb begin
		case (res_q.f3)
			3'd0: begin
				st_bmask = 4'b0001 << res_q.eff[1:0];
				st_rep   = {4{res_q.sdata[7:0]}};
			end
			3'd1: begin
				st_bmask = 4'b0011 << {res_q.eff[1], 1'b0};
				st_rep   = {2{res_q.sdata[15:0]}};
			end
			default: begin
				st_bmask = 4'b1111;
				st_rep   = res_q.sdata;
			end
		endcase
	end
	assign st_mask   = {{8{st_bmask[3]}}, {8{st_bmask[2]}}, {8{st_bmask[1]}}, {8{st_bmask[0]}}};
	assign st_merged = (mem_rdata & ~st_mask) | (st_rep & st_mask);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SQ_IDLE;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			rf_vld_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			// hold until the transfer, then drop unless a new result is posted
			out_valid <= advance || (out_valid && !out_ready);
			if (advance) begin
				pc_q <= res_q.npc;
				if (res_q.halt) halt_q <= 1'b1;
				if (rf_we) rf_vld_q[res_q.rd] <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					img_q      <= !req_type;
					img_addr_q <= image_addr;
					img_data_q <= image_data;
					ins_q      <= '0;
					res_q      <= acc_res;
				end
			end
			SQ_FETCH0: begin
				w0_q <= mem_rdata;
				if (!unaligned) ins_q <= mem_rdata;
			end
			SQ_FETCH1: ins_q <= ins_asm;
			SQ_EXEC:   res_q <= ex_res;
			SQ_MEM: begin
				if (res_q.ld) res_q.wval <= ld_val;
				memw_q <= st_merged;
			end
			SQ_FIN: begin
				if (advance) begin
					status       <= res_q.status;
					exec_pc      <= pc_q;
					instr_word   <= ins_q;
					dest_written <= res_q.wr && res_q.rd != 5'd0;
					dest_reg     <= (res_q.wr && res_q.rd != 5'd0) ? res_q.rd : 5'd0;
					dest_value   <= (res_q.wr && res_q.rd != 5'd0) ? res_q.wval : 32'd0;
					next_pc      <= res_q.npc;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/rv32is_chk.sv @@
module rv32is_chk import rv32is_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic [13:0] image_addr,
	input logic [31:0] image_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [31:0] exec_pc,
	input logic [31:0] instr_word,
	input logic        dest_written,
	input logic [4:0]  dest_reg,
	input logic [31:0] dest_value,
	input logic [31:0] next_pc
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(status))
		else $error("result changed under stall");

	// x0 is never reported as written
	a_no_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dest_written |-> dest_reg != 5'd0)
		else $error("x0 reported as written");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dest_written |-> dest_reg == 5'd0 && dest_value == 32'd0)
		else $error("destination fields not cleared");

	// image writes, halts and fetch faults leave the PC where it was
	a_pc_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_IMAGE || status == ST_HALTED || status == ST_FAULT)
			&& (status != ST_FAULT || instr_word == 32'd0) |-> next_pc == exec_pc)
		else $error("PC moved on an item that must hold it");

endmodule

bind rv32i_instruction_step rv32is_chk u_chk (.*);
